/* rtl/u8sl_pkg.sv */
// shared types and constants of the utf-8 string slicer
`timescale 1ns / 1ps
`default_nettype none
package u8sl_pkg;

  // cap on byte items per string result
  localparam int unsigned OUT_CAP = 64;
  localparam int unsigned EW      = $clog2(OUT_CAP + 1);
  // signed width for index arithmetic, holds any 32-bit index plus a length
  localparam int unsigned IW      = 34;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] MASK3      = 8'hE0;
  localparam logic [7:0] LEAD2      = 8'hC0;
  localparam logic [7:0] MASK4      = 8'hF0;
  localparam logic [7:0] LEAD3      = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISSING  = 2'd1,
    STAT_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               is_last;
    logic               is_empty;
    logic               source_valid;
    logic signed [31:0] start_index;
    logic               start_given;
    logic signed [31:0] stop_index;
    logic               stop_given;
    logic signed [31:0] step_size;
    logic               step_given;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_none;
    status_e    status;
  } out_item_t;

  // character length from the lead byte alone
  function automatic logic [2:0] char_len(input logic [7:0] c);
    logic [2:0] r;
    if (c < ASCII_LIMIT) r = 3'd1;
    else if ((c & MASK3) == LEAD2) r = 3'd2;
    else if ((c & MASK4) == LEAD3) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/u8sl_stream_if.sv */
// valid/ready stream channel carrying one item
`timescale 1ns / 1ps
`default_nettype none
interface u8sl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/utf8_string_slicer.sv */
// top level: python-style character slicing of one utf-8 string
//
// usage: bytes of a string arrive on in_i, one item per byte, one per cycle
// while in_i.ready is high. the item that ends the string (is_last or
// is_empty) also carries start, stop and step with their given flags.
// in_i.ready then drops while the slice runs; the result leaves on out_o as
// one item per selected byte, the final one with out_last set. an empty
// selection, a missing result or a too-long string gives one item with
// out_none set and the matching status.
// steps: after the last byte the sequencer reads the buffer once per
// character to count the characters, then once per character walked
// forward or per byte walked backward, and once per emitted byte; each
// read is followed by a wait state, as the byte buffer has a single
// registered read port. the result ends with a flush.
// reset: buffer contents stay undefined, count and overflow clear, no
// clearing pass. a stalled receiver holds the output register and the
// sequencer waits on its one-byte hold stage, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module utf8_string_slicer #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  u8sl_stream_if.sink      in_i,
  u8sl_stream_if.source    out_o
);

  localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_BYTES + 1);
  localparam int unsigned IW = u8sl_pkg::IW;
  localparam int unsigned EW = u8sl_pkg::EW;

  typedef enum logic [12:0] {
    S_LOAD   = 13'b0000000000001,
    S_DECIDE = 13'b0000000000010,
    S_LEN_RD = 13'b0000000000100,
    S_LEN_WT = 13'b0000000001000,
    S_SETUP  = 13'b0000000010000,
    S_FWD_RD = 13'b0000000100000,
    S_FWD_WT = 13'b0000001000000,
    S_CHK    = 13'b0000010000000,
    S_EM_RD  = 13'b0000100000000,
    S_EM_WT  = 13'b0001000000000,
    S_BK_RD  = 13'b0010000000000,
    S_BK_WT  = 13'b0100000000000,
    S_FINISH = 13'b1000000000000
  } state_e;

  // byte buffer
  logic [7:0] mem_q [MAX_BYTES];
  logic [7:0] rdata_q;
  logic       rd_en, wr_en;
  logic [AW-1:0] rd_addr;

  state_e st_q, st_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;

  // latched slice arguments
  logic                 src_q, src_d;
  logic                 sg_q, sg_d, pg_q, pg_d, tg_q, tg_d;
  logic signed [31:0]   start_q, start_d, stop_in_q, stop_in_d, step_in_q, step_in_d;

  // walk state
  logic [CW-1:0]        len_q, len_d, p_q, p_d, e_q, e_d, q_q, q_d, c_q, c_d;
  logic [31:0]          k_q, k_d;
  logic signed [IW-1:0] idx_q, idx_d, stop_q, stop_d;
  logic                 inf_q, inf_d, fwd_q, fwd_d, need_q_q, need_q_d;
  logic                 first_q, first_d, bskip_q, bskip_d;
  u8sl_pkg::status_e    fin_q, fin_d;

  // hold stage and output register
  logic                 hold_vld_q, hold_vld_d;
  logic [7:0]           hold_q, hold_d;
  logic [EW-1:0]        emitted_q, emitted_d;
  logic                 out_vld_q, out_vld_d;
  u8sl_pkg::out_item_t  out_item_q, out_item_d;
  logic                 push, out_free;
  u8sl_pkg::out_item_t  push_item;

  // combinational helpers
  logic signed [IW-1:0] step_s, start_s, stopx_s, len_s, st_v, kk_v;
  logic signed [IW-1:0] fskip_v, bskip_v;
  logic [2:0]           cl;
  logic [CW:0]          adv_sum;
  logic [CW-1:0]        adv_p, e_adv, qv;
  logic [CW:0]          e_sum;
  logic                 bk_done;

  assign out_free    = !out_vld_q || out_o.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;
  assign in_i.ready  = (st_q == S_LOAD);

  assign step_s  = tg_q ? IW'(step_in_q) : IW'(1);
  assign start_s = IW'(start_q);
  assign stopx_s = IW'(stop_in_q);
  assign len_s   = signed'({{(IW-CW){1'b0}}, len_q});
  assign fskip_v = step_s - IW'(1);
  assign bskip_v = -step_s - IW'(1);
  assign cl      = u8sl_pkg::char_len(rdata_q);

  // one character forward from p, clamped at the end of the string
  assign adv_sum = {1'b0, p_q} + {{(CW-2){1'b0}}, cl};
  assign adv_p   = (adv_sum >= {1'b0, count_q}) ? count_q : adv_sum[CW-1:0];
  // same from the emit pointer, for the lead byte of a forward character
  assign e_sum   = {1'b0, e_q} + {{(CW-2){1'b0}}, cl};
  assign qv      = !need_q_q ? q_q :
                   (e_sum >= {1'b0, count_q}) ? count_q : e_sum[CW-1:0];
  assign e_adv   = e_q + 1'b1;

  // back walk stops at an ascii byte first, else at a non-continuation or byte 0
  assign bk_done = (first_q && !rdata_q[7]) ||
                   !((c_q != '0) && ((rdata_q & u8sl_pkg::CONT_MASK) == u8sl_pkg::CONT_CODE));

  always_comb begin
    st_d = st_q; count_d = count_q; ovf_d = ovf_q;
    src_d = src_q; sg_d = sg_q; pg_d = pg_q; tg_d = tg_q;
    start_d = start_q; stop_in_d = stop_in_q; step_in_d = step_in_q;
    len_d = len_q; p_d = p_q; e_d = e_q; q_d = q_q; c_d = c_q; k_d = k_q;
    idx_d = idx_q; stop_d = stop_q; inf_d = inf_q; fwd_d = fwd_q;
    need_q_d = need_q_q; first_d = first_q; bskip_d = bskip_q; fin_d = fin_q;
    hold_vld_d = hold_vld_q; hold_d = hold_q; emitted_d = emitted_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0;
    push = 1'b0; push_item = '0;
    st_v = '0; kk_v = '0;
    case (st_q)
      S_LOAD: begin
        if (in_i.valid) begin
          if (!in_i.data.is_empty) begin
            if (count_q < CW'(MAX_BYTES)) begin
              wr_en   = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_i.data.is_empty || in_i.data.is_last) begin
            src_d     = in_i.data.source_valid;
            sg_d      = in_i.data.start_given;
            pg_d      = in_i.data.stop_given;
            tg_d      = in_i.data.step_given;
            start_d   = in_i.data.start_index;
            stop_in_d = in_i.data.stop_index;
            step_in_d = in_i.data.step_size;
            st_d      = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        hold_vld_d = 1'b0;
        emitted_d  = '0;
        fin_d      = u8sl_pkg::STAT_OK;
        p_d        = '0;
        len_d      = '0;
        if (!src_q) begin
          fin_d = u8sl_pkg::STAT_MISSING;
          st_d  = S_FINISH;
        end else if (ovf_q) begin
          fin_d = u8sl_pkg::STAT_TOO_LONG;
          st_d  = S_FINISH;
        end else if (count_q == '0) begin
          st_d = S_FINISH;
        end else if (step_s == '0) begin
          fin_d = u8sl_pkg::STAT_MISSING;
          st_d  = S_FINISH;
        end else begin
          st_d = S_LEN_RD;
        end
      end
      S_LEN_RD: begin
        rd_en   = 1'b1;
        rd_addr = p_q[AW-1:0];
        st_d    = S_LEN_WT;
      end
      S_LEN_WT: begin
        len_d = len_q + 1'b1;
        p_d   = adv_p;
        st_d  = (adv_p >= count_q) ? S_SETUP : S_LEN_RD;
      end
      S_SETUP: begin
        p_d   = '0;
        fwd_d = (step_s > 0);
        if (step_s > 0) begin
          st_v = sg_q ? start_s : '0;
          if (st_v < 0) st_v = st_v + len_s;
          if (st_v < 0) st_v = '0;
          idx_d  = st_v;
          k_d    = st_v[31:0];
          inf_d  = !pg_q;
          stop_d = (stopx_s < 0) ? stopx_s + len_s : stopx_s;
        end else begin
          if (!sg_q) st_v = len_s - IW'(1);
          else if (start_s < 0) st_v = start_s + len_s;
          else if (start_s >= len_s) st_v = len_s - IW'(1);
          else st_v = start_s;
          idx_d  = st_v;
          inf_d  = 1'b0;
          stop_d = !pg_q ? -IW'(1) : (stopx_s < 0) ? stopx_s + len_s : stopx_s;
          kk_v   = st_v + IW'(1);
          k_d    = (kk_v > 0) ? kk_v[31:0] : '0;
        end
        st_d = S_FWD_RD;
      end
      S_FWD_RD: begin
        if ((k_q == '0) || (p_q >= count_q)) begin
          st_d = S_CHK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = p_q[AW-1:0];
          st_d    = S_FWD_WT;
        end
      end
      S_FWD_WT: begin
        p_d  = adv_p;
        k_d  = k_q - 1'b1;
        st_d = S_FWD_RD;
      end
      S_CHK: begin
        if (fwd_q) begin
          if ((inf_q || (idx_q < stop_q)) && (p_q < count_q)) begin
            e_d      = p_q;
            need_q_d = 1'b1;
            st_d     = S_EM_RD;
          end else begin
            st_d = S_FINISH;
          end
        end else begin
          if ((idx_q > stop_q) && (p_q != '0)) begin
            q_d      = p_q;
            bskip_d  = 1'b0;
            first_d  = 1'b1;
            st_d     = S_BK_RD;
          end else begin
            st_d = S_FINISH;
          end
        end
      end
      S_EM_RD: begin
        rd_en   = 1'b1;
        rd_addr = e_q[AW-1:0];
        st_d    = S_EM_WT;
      end
      S_EM_WT: begin
        if (!hold_vld_q || out_free) begin
          if (hold_vld_q) begin
            push      = 1'b1;
            push_item = '{out_byte: hold_q, out_last: 1'b0, out_none: 1'b0,
                          status: u8sl_pkg::STAT_OK};
          end
          hold_d     = rdata_q;
          hold_vld_d = 1'b1;
          emitted_d  = emitted_q + 1'b1;
          e_d        = e_adv;
          q_d        = qv;
          need_q_d   = 1'b0;
          if ((emitted_q + 1'b1) == EW'(u8sl_pkg::OUT_CAP)) begin
            st_d = S_FINISH;
          end else if (e_adv >= qv) begin
            if (fwd_q) begin
              p_d   = qv;
              idx_d = idx_q + step_s;
              k_d   = fskip_v[31:0];
              st_d  = S_FWD_RD;
            end else begin
              k_d     = bskip_v[31:0];
              bskip_d = 1'b1;
              first_d = 1'b1;
              st_d    = S_BK_RD;
            end
          end else begin
            st_d = S_EM_RD;
          end
        end
      end
      S_BK_RD: begin
        if (bskip_q && first_q && !((k_q != '0) && (idx_q > stop_q) && (p_q != '0))) begin
          st_d = S_CHK;
        end else begin
          c_d     = first_q ? (p_q - 1'b1) : c_q;
          rd_en   = 1'b1;
          rd_addr = c_d[AW-1:0];
          st_d    = S_BK_WT;
        end
      end
      S_BK_WT: begin
        if (!bk_done) begin
          c_d     = c_q - 1'b1;
          first_d = 1'b0;
          st_d    = S_BK_RD;
        end else begin
          p_d     = c_q;
          idx_d   = idx_q - IW'(1);
          first_d = 1'b1;
          if (bskip_q) begin
            k_d  = k_q - 1'b1;
            st_d = S_BK_RD;
          end else begin
            e_d      = c_q;
            need_q_d = 1'b0;
            st_d     = S_EM_RD;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          push = 1'b1;
          if (hold_vld_q) begin
            push_item = '{out_byte: hold_q, out_last: 1'b1, out_none: 1'b0,
                          status: u8sl_pkg::STAT_OK};
          end else begin
            push_item = '{out_byte: 8'd0, out_last: 1'b1, out_none: 1'b1,
                          status: fin_q};
          end
          hold_vld_d = 1'b0;
          count_d    = '0;
          ovf_d      = 1'b0;
          st_d       = S_LOAD;
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  assign out_vld_d  = push ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);
  assign out_item_d = push ? push_item : out_item_q;

  // buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[count_q[AW-1:0]] <= in_i.data.data_byte;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_LOAD;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      emitted_q  <= '0;
    end else begin
      st_q       <= st_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      emitted_q  <= emitted_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    src_q <= src_d; sg_q <= sg_d; pg_q <= pg_d; tg_q <= tg_d;
    start_q <= start_d; stop_in_q <= stop_in_d; step_in_q <= step_in_d;
    len_q <= len_d; p_q <= p_d; e_q <= e_d; q_q <= q_d; c_q <= c_d; k_q <= k_d;
    idx_q <= idx_d; stop_q <= stop_d; inf_q <= inf_d; fwd_q <= fwd_d;
    need_q_q <= need_q_d; first_q <= first_d; bskip_q <= bskip_d; fin_q <= fin_d;
    hold_q <= hold_d; out_item_q <= out_item_d;
  end

  // fill level never passes the buffer depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BYTES))
    else $error("byte count beyond buffer depth");

  // emit reads stay inside the loaded string
  a_emit_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EM_RD) |-> (e_q < count_q))
    else $error("emit read past end of string");

  // a held byte always counts as emitted
  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (emitted_q != '0))
    else $error("hold stage valid with no emitted byte");

  // a new output item is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(out_item_q)))
    else $error("output item lost under stall");

endmodule
`default_nettype wire

/* sim/utf8_string_slicer_tb.sv */
// testbench of the utf-8 string slicer: directed table, random strings, self-check
`timescale 1ns / 1ps
`default_nettype none
module utf8_string_slicer_tb;

  localparam int          STORE_DEPTH  = 64;
  localparam int          BYTE_CAP     = 64;
  localparam int          ITEM_TARGET  = 230;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 60;

  // one directed row: up to 8 distinct bytes, repeated when the string is longer
  typedef struct {
    int                  nbytes;
    logic [63:0]         pattern;
    logic                src_ok;
    logic                end_empty;
    int                  start_idx;
    logic                start_on;
    int                  stop_idx;
    logic                stop_on;
    int                  step_val;
    logic                step_on;
    logic                typed;
    u8sl_pkg::status_e   typed_status;
  } slice_row_t;

  logic clk;
  logic rst_n;

  u8sl_stream_if #(.T(u8sl_pkg::in_item_t))  in_if ();
  u8sl_stream_if #(.T(u8sl_pkg::out_item_t)) out_if ();

  utf8_string_slicer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // expected result bytes in arrival order
  u8sl_pkg::out_item_t slice_q[$];
  logic [7:0]  char_buf[STORE_DEPTH];
  int          buf_fill;
  bit          buf_overflow;
  int          emitted;

  int          mismatches;
  int          quiet_cycles;
  int          items_sent;
  bit          idle_on;
  bit          hold_req;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic u8sl_pkg::out_item_t mk_item(logic [7:0] b, logic none,
                                                  u8sl_pkg::status_e st);
    u8sl_pkg::out_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    r.out_none = none;
    r.status   = st;
    return r;
  endfunction

  // bytes taken by one character, read off its lead byte
  function automatic longint lead_len(logic [7:0] c);
    if (c[7] == 1'b0) return 1;
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    return 4;
  endfunction

  // step k characters ahead of byte position p, clipped at n
  function automatic longint skip_fwd(longint p, longint k, longint n);
    longint i;
    i = 0;
    while (p < n && i < k) begin
      p = p + lead_len(char_buf[p]);
      if (p > n) p = n;
      i++;
    end
    return p;
  endfunction

  // one character back: hop over continuation bytes, stop at byte 0
  function automatic longint skip_back(longint p);
    longint c;
    c = p - 1;
    if (char_buf[c][7]) begin
      while (c > 0 && char_buf[c][7:6] == 2'b10) c--;
    end
    return c;
  endfunction

  function automatic void emit_span(longint a, longint b);
    while (a < b && emitted < BYTE_CAP) begin
      slice_q.push_back(mk_item(char_buf[a], 1'b0, u8sl_pkg::STAT_OK));
      emitted++;
      a++;
    end
  endfunction

  function automatic void slice_string(u8sl_pkg::in_item_t it);
    longint n, nchars, p, q, idx, j, start, stop, step;
    n      = longint'(buf_fill);
    start  = longint'(it.start_index);
    stop   = longint'(it.stop_index);
    step   = it.step_given ? longint'(it.step_size) : 1;
    emitted = 0;
    if (!it.source_valid) begin
      slice_q.push_back(mk_item(8'h00, 1'b1, u8sl_pkg::STAT_MISSING));
      emitted = 1;
    end else if (buf_overflow) begin
      slice_q.push_back(mk_item(8'h00, 1'b1, u8sl_pkg::STAT_TOO_LONG));
      emitted = 1;
    end else if (n == 0) begin
      slice_q.push_back(mk_item(8'h00, 1'b1, u8sl_pkg::STAT_OK));
      emitted = 1;
    end else if (step == 0) begin
      slice_q.push_back(mk_item(8'h00, 1'b1, u8sl_pkg::STAT_MISSING));
      emitted = 1;
    end else begin
      nchars = 0;
      p = 0;
      while (p < n) begin
        p = skip_fwd(p, 1, n);
        nchars++;
      end
      if (step == 1) begin
        if (!it.start_given) start = 0;
        if (start < 0) begin
          start += nchars;
          if (start < 0) start = 0;
        end
        p = skip_fwd(0, start, n);
        if (!it.stop_given) emit_span(p, n);
        else begin
          if (stop < 0) stop += nchars;
          q = skip_fwd(p, stop - start, n);
          emit_span(p, q);
        end
      end else if (step > 1) begin
        if (!it.start_given) start = 0;
        if (!it.stop_given) stop = 64'sh7FFF_FFFF_FFFF_FFFF;
        if (start < 0) begin
          start += nchars;
          if (start < 0) start = 0;
        end
        if (stop < 0) begin
          stop += nchars;
          if (stop < 0) stop = 0;
        end
        p = skip_fwd(0, start, n);
        idx = start;
        while (idx < stop && p < n) begin
          q = skip_fwd(p, 1, n);
          emit_span(p, q);
          p = skip_fwd(q, step - 1, n);
          idx += step;
        end
      end else begin
        // backward walk
        if (!it.start_given) start = nchars - 1;
        else if (start < 0) start += nchars;
        else if (start >= nchars) start = nchars - 1;
        if (!it.stop_given) stop = -1;
        else if (stop < 0) stop += nchars;
        p = skip_fwd(0, start + 1, n);
        idx = start;
        while (idx > stop && p > 0) begin
          q = p;
          p = skip_back(p);
          idx--;
          emit_span(p, q);
          j = 1;
          while (j < -step && idx > stop && p > 0) begin
            p = skip_back(p);
            idx--;
            j++;
          end
        end
      end
      if (emitted == 0) slice_q.push_back(mk_item(8'h00, 1'b1, u8sl_pkg::STAT_OK));
    end
    slice_q[slice_q.size() - 1].out_last = 1'b1;
  endfunction

  // update buffer state with one accepted item and queue what it causes
  function automatic void predict_item(u8sl_pkg::in_item_t it);
    if (!it.is_empty) begin
      if (buf_fill < STORE_DEPTH) begin
        char_buf[buf_fill] = it.data_byte;
        buf_fill++;
      end else begin
        buf_overflow = 1'b1;
      end
    end
    if (it.is_empty || it.is_last) begin
      slice_string(it);
      buf_fill     = 0;
      buf_overflow = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_item(u8sl_pkg::in_item_t it);
    // random idle burst before the item
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    predict_item(it);
  endtask

  function automatic logic [31:0] rand_index();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'h8000_0000 | $urandom_range(0, 3);
      2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 28)) - 14);
    endcase
  endfunction

  // send a whole string; the final item carries the slice fields
  task automatic send_string(logic [7:0] bytes_q[$], logic end_empty, logic src_ok,
                             logic [31:0] start_idx, logic start_on,
                             logic [31:0] stop_idx, logic stop_on,
                             logic [31:0] step_val, logic step_on);
    u8sl_pkg::in_item_t it;
    int nb;
    nb = bytes_q.size();
    for (int i = 0; i <= nb; i++) begin
      if (i == nb && !end_empty) break;
      it.data_byte    = (i < nb) ? bytes_q[i] : 8'($urandom());
      it.is_empty     = (i == nb);
      it.is_last      = (i == nb - 1 && !end_empty) || (i == nb && $urandom_range(0, 1));
      // fields on non-final items are ignored, fill them with noise
      it.source_valid = 1'($urandom_range(0, 1));
      it.start_index  = $urandom();
      it.start_given  = 1'($urandom_range(0, 1));
      it.stop_index   = $urandom();
      it.stop_given   = 1'($urandom_range(0, 1));
      it.step_size    = $urandom();
      it.step_given   = 1'($urandom_range(0, 1));
      if (it.is_last || it.is_empty) begin
        it.source_valid = src_ok;
        it.start_index  = start_idx;
        it.start_given  = start_on;
        it.stop_index   = stop_idx;
        it.stop_given   = stop_on;
        it.step_size    = step_val;
        it.step_given   = step_on;
      end
      send_item(it);
    end
  endtask

  // one random utf-8 character, or now and then a raw byte
  task automatic add_char(ref logic [7:0] q[$]);
    int clen;
    if ($urandom_range(0, 7) == 0) begin
      q.push_back(8'($urandom()));
    end else begin
      clen = $urandom_range(1, 4);
      case (clen)
        1:       q.push_back(8'($urandom_range(8'h00, 8'h7F)));
        2:       q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3:       q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: q.push_back(8'($urandom_range(8'hF0, 8'hFF)));
      endcase
      for (int i = 1; i < clen; i++) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
  endtask

  // ---------------------------------------------------------------- directed table
  // ascii, 2-byte, 3-byte, then a 4-byte lead cut short by the string end
  localparam logic [63:0] MIXED = 64'h9FF0_AC82_E2A9_C341;

  slice_row_t rows[] = '{
    // missing source wins over everything
    '{3, MIXED, 1'b0, 1'b0, 0, 1'b0, 0, 1'b0, 1, 1'b0, 1'b1, u8sl_pkg::STAT_MISSING},
    // empty string with step zero is still an ok empty result
    '{0, MIXED, 1'b1, 1'b1, 0, 1'b0, 0, 1'b0, 0, 1'b1, 1'b1, u8sl_pkg::STAT_OK},
    '{4, MIXED, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b1, 1'b1, u8sl_pkg::STAT_MISSING},
    '{65, MIXED, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, 1, 1'b1, 1'b1, u8sl_pkg::STAT_TOO_LONG},
    '{8, MIXED, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, 1, 1'b0, 1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 1, 1'b1, 3, 1'b1, 1, 1'b1, 1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, -2, 1'b1, -1, 1'b1, 1, 1'b0, 1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, 2, 1'b1, 1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, -1, 1'b1, 1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 5, 1'b1, -7, 1'b1, -2, 1'b1, 1'b0, u8sl_pkg::STAT_OK},
    // start past the end with the largest step selects nothing
    '{8, MIXED, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1,
      32'h7FFF_FFFF, 1'b1, 1'b1, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 0, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1,
      1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, 3, 1'b1,
      1'b0, u8sl_pkg::STAT_OK},
    // empty flag after loaded bytes keeps them
    '{3, MIXED, 1'b1, 1'b1, 0, 1'b0, 0, 1'b0, -1, 1'b1, 1'b0, u8sl_pkg::STAT_OK},
    '{8, MIXED, 1'b1, 1'b0, 3, 1'b1, 1, 1'b1, 1, 1'b1, 1'b1, u8sl_pkg::STAT_OK},
    // continuation bytes at the buffer start stop the backward walk
    '{3, 64'h0000_0000_0041_8080, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, -1, 1'b1, 1'b0,
      u8sl_pkg::STAT_OK},
    '{1, 64'h0000_0000_0000_00FF, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0, 1, 1'b0, 1'b0,
      u8sl_pkg::STAT_OK},
    '{2, 64'h0000_0000_0000_E200, 1'b1, 1'b0, -9, 1'b1, 9, 1'b1, -3, 1'b1, 1'b0,
      u8sl_pkg::STAT_OK}
  };

  // ---------------------------------------------------------------- receiver
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the block backs up into its input
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (slice_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: byte %h last %b none %b status %0d",
                   out_if.data.out_byte, out_if.data.out_last, out_if.data.out_none,
                   out_if.data.status);
      end else begin
        u8sl_pkg::out_item_t exp_item;
        exp_item = slice_q.pop_front();
        if (exp_item.out_byte !== out_if.data.out_byte
            || exp_item.out_last !== out_if.data.out_last
            || exp_item.out_none !== out_if.data.out_none
            || exp_item.status !== out_if.data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte/last/none/status %h %b %b %0d, got %h %b %b %0d",
                     exp_item.out_byte, exp_item.out_last, exp_item.out_none,
                     exp_item.status, out_if.data.out_byte, out_if.data.out_last,
                     out_if.data.out_none, out_if.data.status);
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    logic [7:0]          str_q[$];
    u8sl_pkg::in_item_t  zero_item;
    int                  target_len;
    int                  rows_done;
    zero_item    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = zero_item;
    rst_n        = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    buf_fill     = 0;
    buf_overflow = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    rows_done = 0;
    foreach (rows[r]) begin
      str_q.delete();
      for (int i = 0; i < rows[r].nbytes; i++) str_q.push_back(rows[r].pattern[8*(i%8) +: 8]);
      send_string(str_q, rows[r].end_empty, rows[r].src_ok,
                  rows[r].start_idx, rows[r].start_on, rows[r].stop_idx, rows[r].stop_on,
                  rows[r].step_val, rows[r].step_on);
      // single-item result read straight off the row
      if (rows[r].typed) begin
        void'(slice_q.pop_back());
        slice_q.push_back(mk_item(8'h00, 1'b1, rows[r].typed_status));
        slice_q[slice_q.size() - 1].out_last = 1'b1;
      end
      rows_done++;
      // long receiver hold-off while a long string is on its way
      if (rows_done == 3) hold_req = 1'b1;
    end

    // random part
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - 30) idle_on = 1'b0;
      str_q.delete();
      case ($urandom_range(0, 19))
        0:       target_len = $urandom_range(65, 70);
        1, 2:    target_len = $urandom_range(30, 64);
        default: target_len = $urandom_range(0, 12);
      endcase
      while (str_q.size() < target_len) add_char(str_q);
      while (str_q.size() > STORE_DEPTH + 6) void'(str_q.pop_back());
      send_string(str_q, str_q.size() == 0 || $urandom_range(0, 9) == 0,
                  $urandom_range(0, 19) != 0,
                  rand_index(), $urandom_range(0, 3) != 0,
                  rand_index(), $urandom_range(0, 3) != 0,
                  ($urandom_range(0, 9) == 0) ? rand_index()
                                              : 32'($signed($urandom_range(0, 8)) - 4),
                  $urandom_range(0, 4) != 0);
    end
    in_if.valid <= 1'b0;

    wait (slice_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && slice_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
